/* src/sorted_timer_queue_defines.svh */
// Assertion macros used by the timer queue top level.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define STQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define STQ_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

/* src/stq_pkg.sv */
// Package with the timer queue constants and types.
`timescale 1ns / 1ps
package stq_pkg;
    localparam int NumTimersDef = 16;
    localparam int TimeWidthDef = 32;
    localparam int MaxRes       = 16;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_RESET = 3'd2;
    localparam logic [2:0] OP_TICK  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BAD_ID = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic        expired;
        logic [3:0]  slot;
        logic [31:0] tag_a;
        logic [31:0] tag_b;
        logic [31:0] remaining;
        logic [31:0] length_out;
        logic        last;
    } t_result;
endpackage

/* src/sorted_timer_queue.sv */
// Top level of the sorted timer queue: sequencer, slot store and order list.
// Start scans for the lowest free slot, computes the end time, scans for the insert point and
//   shifts the tail up (a full pool gives ST_FULL); stop removes; reset removes and re-inserts.
// Tick expiries: each result comes after the due head is removed from the queue (one-shot) or
//   removed and inserted again (periodic, re-queued).
// One word at a time: s_tready is high only in idle, which follows the final result handshake.
`timescale 1ns / 1ps
// Reset (synchronous, active low) clears time, slot use, queue count and control state.
module sorted_timer_queue #(
    parameter int NUM_TIMERS = stq_pkg::NumTimersDef,
    parameter int TIME_WIDTH = stq_pkg::TimeWidthDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: timer_id[3:0], length_ticks[35:4], periodic[36], tag_a[68:37],
    // tag_b[100:69], zero fill[103:101]
    input  logic [103:0] s_tdata,
    // tuser: op[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], slot[5:2], out_tag_a[37:6], out_tag_b[69:38],
    // remaining[101:70], length_out[133:102], zero fill[135:134]
    output logic [135:0] m_tdata,
    // tuser: expired
    output logic         m_tuser,
    output logic         m_tlast
);
`include "sorted_timer_queue_defines.svh"
    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int TW = TIME_WIDTH;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;  // scan for free slot
    localparam logic [3:0] S_RMV   = 4'd2;  // scan queue for slot, shift down
    localparam logic [3:0] S_INS   = 4'd3;  // scan for insert point
    localparam logic [3:0] S_SHIFT = 4'd4;  // shift up to open a hole
    localparam logic [3:0] S_OUT   = 4'd5;  // result waits
    localparam logic [3:0] S_TCHK  = 4'd6;  // check queue head
    localparam logic [3:0] S_QRY   = 4'd7;
    localparam logic [3:0] S_SETUP = 4'd8;  // compute new end time
    localparam logic [3:0] S_TLAST = 4'd9;  // decide whether this expiry ends the tick

    // slot store
    logic [TW-1:0] r_end  [NUM_TIMERS];
    logic [TW-1:0] r_per  [NUM_TIMERS];
    logic [TW-1:0] r_len  [NUM_TIMERS];
    logic          r_mode [NUM_TIMERS];
    logic [31:0]   r_ta   [NUM_TIMERS];
    logic [31:0]   r_tb   [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_use;
    logic [IW-1:0] r_q [NUM_TIMERS];
    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_now;

    logic [3:0]    r_st;
    logic [2:0]    r_op;
    logic [IW-1:0] r_s;      // slot under work
    logic [CW-1:0] r_i;      // scan index
    logic [CW-1:0] r_pos;    // insert point
    logic [TW-1:0] r_key;    // length, then end time being inserted
    logic [4:0]    r_nres;
    logic          r_tick_rm;
    logic          r_mode_in;
    logic [31:0]   r_ta_in;
    logic [31:0]   r_tb_in;
    stq_pkg::t_result r_res;

    wire [2:0]  w_op  = s_tuser;
    wire [3:0]  w_id  = s_tdata[3:0];
    wire [31:0] w_len = s_tdata[35:4];
    wire        w_acc = s_tvalid && s_tready;
    wire [TW-1:0] w_lenm = TW'(w_len);
    wire        w_idok = (32'(w_id) < NUM_TIMERS) && r_use[IW'(w_id)];

    assign s_tready = (r_st == S_IDLE);
    assign m_tvalid = (r_st == S_OUT);
    assign m_tdata  = {2'b00, r_res.length_out, r_res.remaining, r_res.tag_b,
                       r_res.tag_a, r_res.slot, r_res.status};
    assign m_tuser  = r_res.expired;
    assign m_tlast  = r_res.last;

    wire [IW-1:0] w_ix   = r_i[IW-1:0];
    wire [IW-1:0] w_qix  = r_q[w_ix];
    wire [IW-1:0] w_head = r_q[0];
    // shared unit: one add and one compare
    wire [TW-1:0] w_sum = ((r_op == stq_pkg::OP_TICK) ? r_end[r_s] : r_now) + r_per[r_s];
    wire          w_le  = r_end[w_qix] <= r_key;
    // another timer is due on this tick and the event budget is not spent
    wire          w_due = (r_nres != 5'(stq_pkg::MaxRes)) && (r_cnt != '0) &&
                          (r_end[w_head] <= r_now);

    function automatic stq_pkg::t_result res_word(logic [1:0] st, logic ex, logic [3:0] sl,
                                                  logic [31:0] tg_a, logic [31:0] tg_b,
                                                  logic [31:0] rem, logic [31:0] ln,
                                                  logic lst);
        stq_pkg::t_result r;
        r.status     = st;
        r.expired    = ex;
        r.slot       = sl;
        r.tag_a      = tg_a;
        r.tag_b      = tg_b;
        r.remaining  = rem;
        r.length_out = ln;
        r.last       = lst;
        return r;
    endfunction

    function automatic stq_pkg::t_result blank(logic [1:0] st);
        stq_pkg::t_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_use <= '0;
            r_cnt <= '0;
            r_now <= '0;
            r_nres <= '0;
            r_op <= '0;
            r_i <= '0;
            r_tick_rm <= 1'b0;
            r_res <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: if (w_acc) begin
                    r_op <= w_op;
                    r_i <= '0;
                    r_s <= IW'(w_id);
                    r_key <= w_lenm;
                    r_nres <= '0;
                    r_tick_rm <= 1'b0;
                    if (w_op == stq_pkg::OP_START) begin
                        // park mode and tags until a slot is found
                        r_mode_in <= s_tdata[36];
                        r_ta_in <= s_tdata[68:37];
                        r_tb_in <= s_tdata[100:69];
                        r_st <= S_FIND;
                    end else if (w_op == stq_pkg::OP_TICK) begin
                        r_now <= r_now + 1'b1;
                        r_st <= S_TCHK;
                    end else if (!w_idok && (w_op == stq_pkg::OP_STOP ||
                                             w_op == stq_pkg::OP_RESET ||
                                             w_op == stq_pkg::OP_QUERY)) begin
                        r_res <= blank(w_op == stq_pkg::OP_STOP ?
                                       stq_pkg::ST_OK : stq_pkg::ST_BAD_ID);
                        r_st <= S_OUT;
                    end else if (w_op == stq_pkg::OP_STOP ||
                                 w_op == stq_pkg::OP_RESET) begin
                        r_st <= S_RMV;
                    end else if (w_op == stq_pkg::OP_QUERY) begin
                        r_st <= S_QRY;
                    end else begin
                        r_res <= blank(stq_pkg::ST_OK);
                        r_st <= S_OUT;
                    end
                end
                S_FIND: begin
                    if (r_i == CW'(NUM_TIMERS)) begin
                        r_res <= blank(stq_pkg::ST_FULL);
                        r_st <= S_OUT;
                    end else if (!r_use[w_ix]) begin
                        r_s <= w_ix;
                        r_use[w_ix] <= 1'b1;
                        r_len[w_ix] <= r_key;
                        r_per[w_ix] <= (r_key == '0) ? TW'(1) : r_key;
                        r_mode[w_ix] <= r_mode_in;
                        r_ta[w_ix] <= r_ta_in;
                        r_tb[w_ix] <= r_tb_in;
                        r_st <= S_SETUP;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_RMV: begin
                    // find slot, then shift the tail down one place
                    if (r_i + 1'b1 >= r_cnt) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_i <= '0;
                        r_tick_rm <= 1'b0;
                        if (r_op == stq_pkg::OP_STOP) begin
                            r_use[r_s] <= 1'b0;
                            r_res <= blank(stq_pkg::ST_OK);
                            r_st <= S_OUT;
                        end else if (r_op == stq_pkg::OP_TICK && !r_mode[r_s]) begin
                            r_use[r_s] <= 1'b0;
                            r_st <= S_TLAST;
                        end else begin
                            if (r_op == stq_pkg::OP_RESET) begin
                                // a zero length keeps the old one
                                if (r_key != '0) r_len[r_s] <= r_key;
                                r_per[r_s] <= (r_key != '0) ? r_key :
                                              ((r_len[r_s] == '0) ? TW'(1) : r_len[r_s]);
                            end
                            r_st <= S_SETUP;
                        end
                    end else begin
                        if (r_tick_rm || w_qix == r_s) begin
                            r_tick_rm <= 1'b1;
                            r_q[w_ix] <= r_q[IW'(r_i + 1'b1)];
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SETUP: begin
                    r_end[r_s] <= w_sum;
                    r_key <= w_sum;
                    r_i <= '0;
                    r_st <= S_INS;
                    if (r_op == stq_pkg::OP_START) begin
                        r_res <= res_word(stq_pkg::ST_OK, 1'b0, 4'(r_s), 32'd0, 32'd0,
                                          32'd0, 32'd0, 1'b1);
                    end else if (r_op == stq_pkg::OP_RESET) begin
                        r_res <= blank(stq_pkg::ST_OK);
                    end
                end
                S_INS: begin
                    // go past every entry that ends at or before the new end
                    if (r_i < r_cnt && w_le) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_pos <= r_i;
                        r_i <= r_cnt;
                        r_st <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_i == r_pos) begin
                        r_q[w_ix] <= r_s;
                        r_cnt <= r_cnt + 1'b1;
                        r_st <= (r_op == stq_pkg::OP_TICK) ? S_TLAST : S_OUT;
                    end else begin
                        r_q[w_ix] <= r_q[IW'(r_i - 1'b1)];
                        r_i <= r_i - 1'b1;
                    end
                end
                S_TCHK: begin
                    if (w_due) begin
                        r_s <= w_head;
                        r_res <= res_word(stq_pkg::ST_OK, 1'b1, 4'(w_head), r_ta[w_head],
                                          r_tb[w_head], 32'd0, 32'd0, 1'b0);
                        r_nres <= r_nres + 1'b1;
                        r_tick_rm <= 1'b1;
                        r_i <= '0;
                        r_st <= S_RMV;
                    end else begin
                        r_res <= blank(stq_pkg::ST_OK);
                        r_st <= S_OUT;
                    end
                end
                S_TLAST: begin
                    // mark the event last when nothing more is due on this tick
                    r_res.last <= !w_due;
                    r_st <= S_OUT;
                end
                S_QRY: begin
                    r_res <= res_word(stq_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 32'd0,
                                      32'((r_now < r_end[r_s]) ? r_end[r_s] - r_now : TW'(0)),
                                      32'(r_len[r_s]), 1'b1);
                    r_st <= S_OUT;
                end
                S_OUT: if (m_tready) begin
                    r_st <= (r_op == stq_pkg::OP_TICK && r_res.expired && !r_res.last) ?
                            S_TCHK : S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `STQ_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_tready, !m_tvalid)
    `STQ_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(NUM_TIMERS))
    `STQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid)
endmodule
